[hw/rtl/vsd_pkg.sv]
// shared types and constants for the varint stream decoder
`default_nettype none

package vsd_pkg;

    // bits of payload carried by one encoded byte
    localparam int unsigned GROUP_BITS = 7;
    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned COUNT_W    = 4;

    // group caps for 32-bit and 64-bit values
    localparam logic [COUNT_W-1:0] CAP_NARROW = 4'd5;
    localparam logic [COUNT_W-1:0] CAP_WIDE   = 4'd10;

    // highest group count whose shift still lands inside the value
    localparam logic [COUNT_W-1:0] LAST_GROUP = 4'd9;

    // bit position of the continuation flag within a byte
    localparam int unsigned CONT_POS = 7;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WIDE_MODE   = 4'd0,
        CFG_SIGNED_MODE = 4'd1
    } cfg_index_t;

    // completed value handed from the accumulate stage to the finish stage
    typedef struct packed {
        logic [VALUE_W-1:0] raw;
        logic               eof;
    } vsd_raw_t;

endpackage : vsd_pkg

`default_nettype wire

[hw/rtl/vsd_accum.sv]
// accumulate stage: gathers 7-bit groups and registers each completed raw value
`default_nettype none

module vsd_accum
    import vsd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 end_of_data,
    input  wire logic                 wide_mode,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output vsd_raw_t                  res
);

    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               res_valid_reg, res_valid_next;
    vsd_raw_t           res_reg, res_next;

    logic               accept;
    logic               produce;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] cap;
    logic [6:0]         shift_amt;
    logic [VALUE_W-1:0] group_shifted;
    logic [VALUE_W-1:0] acc_merged;

    // a new byte enters whenever the result register is free or draining
    assign in_ready = !res_valid_reg || res_ready;
    assign accept   = in_valid && in_ready;

    // group merge and end-of-value decision
    always_comb
    begin
        cap           = wide_mode ? CAP_WIDE : CAP_NARROW;
        shift_amt     = 7'(count_reg) * 7'(GROUP_BITS);
        group_shifted = {{(VALUE_W-GROUP_BITS){1'b0}}, in_byte[GROUP_BITS-1:0]} << shift_amt;
        acc_merged    = (count_reg <= LAST_GROUP) ? (acc_reg | group_shifted) : acc_reg;
        count_inc     = count_reg + 4'd1;

        acc_next   = acc_reg;
        count_next = count_reg;
        produce    = 1'b0;
        res_next   = res_reg;

        if (accept)
        begin
            if (end_of_data)
            begin
                produce      = 1'b1;
                res_next.raw = acc_reg;
                res_next.eof = 1'b1;
                acc_next     = '0;
                count_next   = '0;
            end
            else if (!in_byte[CONT_POS] || count_inc >= cap)
            begin
                produce      = 1'b1;
                res_next.raw = acc_merged;
                res_next.eof = 1'b0;
                acc_next     = '0;
                count_next   = '0;
            end
            else
            begin
                acc_next   = acc_merged;
                count_next = count_inc;
            end
        end

        res_valid_next = (res_valid_reg && !res_ready) || produce;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule : vsd_accum

`default_nettype wire

[hw/rtl/vsd_finish.sv]
// finish stage: width mask and sign rule (an odd pattern gives minus half) into the output register
`default_nettype none

module vsd_finish
    import vsd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 res_valid,
    output logic                      res_ready,
    input  wire vsd_raw_t             res,
    input  wire logic                 wide_mode,
    input  wire logic                 signed_mode,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [VALUE_W-1:0]        out_value,
    output logic                      out_eof
);

    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               eof_reg, eof_next;

    logic               accept;
    logic [VALUE_W-1:0] masked;
    logic [VALUE_W-1:0] half;

    assign res_ready = !out_valid_reg || out_ready;
    assign accept    = res_valid && res_ready;

    // mask to the active width, then apply the sign rule
    always_comb
    begin
        masked = wide_mode ? res.raw : {32'b0, res.raw[31:0]};
        half   = masked >> 1;

        value_next = value_reg;
        eof_next   = eof_reg;
        if (accept)
        begin
            if (signed_mode && masked[0])
                value_next = '0 - half;
            else if (signed_mode)
                value_next = half;
            else
                value_next = masked;
            eof_next = res.eof;
        end

        out_valid_next = (out_valid_reg && !out_ready) || accept;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        eof_reg   <= eof_next;
    end

    assign out_valid = out_valid_reg;
    assign out_value = value_reg;
    assign out_eof   = eof_reg;

endmodule : vsd_finish

`default_nettype wire

[hw/rtl/varint_stream_decoder.sv]
// top level of the varint stream decoder: config registers and the two stages
//
// Decodes little-endian base-128 varints from a byte stream.
// Input channel: one transaction per byte on s_tdata[7:0]; s_tuser high
// marks end of data, in which case the byte is ignored.
// Output channel: one transaction per completed value on m_tdata (64-bit
// pattern, two's complement in signed mode); m_tuser flags a value cut
// short by end of data.
// Config channel: cfg_index 0 selects wide mode (64-bit, ten groups),
// 1 selects signed mode; cfg_data[0] is the new value. Always ready;
// write only while no byte is in flight.
// Throughput: one byte per cycle while the output is not stalled. A value
// passes through the accumulate register, then the output register with
// the sign rule, before it appears on the output.
// Reset clears the accumulator, the group count, both mode bits and all
// valid flags. When the receiver stalls, the output register holds its
// transaction and one more completed value waits in the accumulate stage;
// from then on the input takes no byte until the output register drains.
`default_nettype none

module varint_stream_decoder
    import vsd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input bytes
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] in_byte
    input  wire logic                   s_tuser,   // [0] end_of_data
    // decoded values
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [VALUE_W-1:0]          m_tdata,   // [63:0] decoded_value
    output logic                        m_tuser,   // [0] eof_error
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic                   cfg_data
);

    logic     wide_mode_reg, wide_mode_next;
    logic     signed_mode_reg, signed_mode_next;
    logic     res_valid;
    logic     res_ready;
    vsd_raw_t res;

    assign cfg_ready = 1'b1;

    // configuration register decode
    always_comb
    begin
        wide_mode_next   = wide_mode_reg;
        signed_mode_next = signed_mode_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WIDE_MODE:   wide_mode_next   = cfg_data;
                CFG_SIGNED_MODE: signed_mode_next = cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_mode_reg   <= 1'b0;
            signed_mode_reg <= 1'b0;
        end
        else
        begin
            wide_mode_reg   <= wide_mode_next;
            signed_mode_reg <= signed_mode_next;
        end
    end

    // group accumulation
    vsd_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_byte     (s_tdata),
        .end_of_data (s_tuser),
        .wide_mode   (wide_mode_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // width mask, sign rule and output register
    vsd_finish u_finish (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .wide_mode   (wide_mode_reg),
        .signed_mode (signed_mode_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_value   (m_tdata),
        .out_eof     (m_tuser)
    );

endmodule : varint_stream_decoder

`default_nettype wire

[bench/vsd_checker.sv]
`timescale 1ns / 100ps
// checker for the varint stream decoder: predicts decoded values and compares them

module vsd_checker
    import vsd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] in_byte
    input  wire logic                   s_tuser,   // [0] end_of_data
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [VALUE_W-1:0]     m_tdata,   // [63:0] decoded_value
    input  wire logic                   m_tuser,   // [0] eof_error
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic                   cfg_data,
    output int                          fail_count,
    output int                          pending_count
);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               eof;
    } decoded_t;

    // decoded values still owed by the block, oldest first
    decoded_t expected_values[$];

    // shadow of the decoder state and its mode bits
    logic [VALUE_W-1:0] acc;
    logic [COUNT_W-1:0] groups;
    logic               wide_mode;
    logic               signed_mode;

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
    end

    // width mask, then the low-bit sign rule
    function automatic logic [VALUE_W-1:0] shape_value(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] d;
        logic [VALUE_W-1:0] half;
        d = wide_mode ? raw : {32'h0, raw[31:0]};
        if (!signed_mode)
            return d;
        half = d >> 1;
        return d[0] ? (64'h0 - half) : half;
    endfunction

    // fold one input transaction into the shadow state
    task automatic absorb_byte(input logic [7:0] b, input logic eod);
        decoded_t           item;
        int                 shift;
        logic [COUNT_W-1:0] cap;
        if (eod)
        begin
            item.value = shape_value(acc);
            item.eof   = 1'b1;
            expected_values.push_back(item);
            acc    = '0;
            groups = '0;
        end
        else
        begin
            cap   = wide_mode ? CAP_WIDE : CAP_NARROW;
            shift = int'(groups) * GROUP_BITS;
            if (shift < VALUE_W)
                acc = acc | (VALUE_W'(b[GROUP_BITS-1:0]) << shift);
            groups = groups + 1'b1;
            // value ends on a clear continuation bit or at the group cap
            if (!b[CONT_POS] || groups >= cap)
            begin
                item.value = shape_value(acc);
                item.eof   = 1'b0;
                expected_values.push_back(item);
                acc    = '0;
                groups = '0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        decoded_t want;
        if (!rst_n)
        begin
            acc         = '0;
            groups      = '0;
            wide_mode   = 1'b0;
            signed_mode = 1'b0;
            expected_values.delete();
        end
        else
        begin
            // output transaction against the oldest expectation
            if (m_tvalid && m_tready)
            begin
                if (expected_values.size() == 0)
                begin
                    $error("decoded_value %h arrived with no expectation waiting", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_values.pop_front();
                    if (m_tdata !== want.value)
                    begin
                        $error("decoded_value mismatch: expected %h, actual %h",
                               want.value, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== want.eof)
                    begin
                        $error("eof_error mismatch: expected %b, actual %b",
                               want.eof, m_tuser);
                        fail_count++;
                    end
                end
            end

            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WIDE_MODE:   wide_mode   = cfg_data;
                    CFG_SIGNED_MODE: signed_mode = cfg_data;
                    default:         ;
                endcase
            end

            // input transaction
            if (s_tvalid && s_tready)
                absorb_byte(s_tdata, s_tuser);
        end
        pending_count = expected_values.size();
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// top of the varint stream decoder bench: clock, reset, stimulus and verdict

module testbench;
    import vsd_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PHASE_ITEMS    = 95;
    localparam int ENCODED_MAX    = 10;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 4'd9;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;   // [7:0] in_byte
    logic                   s_tuser;   // [0] end_of_data
    logic                   m_tvalid;
    logic                   m_tready;
    logic [VALUE_W-1:0]     m_tdata;   // [63:0] decoded_value
    logic                   m_tuser;   // [0] eof_error
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic                   cfg_data;
    int                     fail_count;
    int                     pending_count;

    int   tx_idle_pct;
    int   rx_stall_pct;
    logic hold_go;
    int   items_sent;
    logic cur_wide;

    varint_stream_decoder uut (.*);
    vsd_checker           checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // receiver side: random stalls plus one long hold-off
    initial
    begin : receiver
        logic hold_taken;
        hold_taken = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_taken)
            begin
                hold_taken = 1'b1;
                m_tready   = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                m_tready = ($urandom_range(99) < rx_stall_pct) ? 1'b0 : 1'b1;
        end
    end

    // offer one input transaction and wait until it is taken
    task automatic put_byte(input logic [7:0] b, input logic eod);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = eod;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // register write once the decoder has drained
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic d);
        s_tvalid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == CFG_WIDE_MODE)
            cur_wide = d;
    endtask

    // one varint, a cut-short varint or raw noise
    task automatic send_random_run();
        int         cap;
        int         len;
        int         kind;
        logic [7:0] b;
        cap  = cur_wide ? int'(CAP_WIDE) : int'(CAP_NARROW);
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            // well-formed value, payload biased towards the extremes
            len = $urandom_range(cap, 1);
            for (int i = 0; i < len; i++)
            begin
                b = 8'($urandom);
                case ($urandom_range(3))
                    0:       b[6:0] = 7'h7f;
                    1:       b[6:0] = 7'h00;
                    default: ;
                endcase
                if (i != len - 1)
                    b[CONT_POS] = 1'b1;
                else if (len != cap)
                    b[CONT_POS] = 1'b0;
                put_byte(b, 1'b0);
            end
        end
        else if (kind < 85)
        begin
            // stream ends part way through a value
            len = $urandom_range(cap - 1, 0);
            for (int i = 0; i < len; i++)
            begin
                b = 8'($urandom);
                b[CONT_POS] = 1'b1;
                put_byte(b, 1'b0);
            end
            put_byte(8'($urandom), 1'b1);
        end
        else
        begin
            // unstructured bytes with the odd end marker
            len = $urandom_range(ENCODED_MAX + 2, 1);
            for (int i = 0; i < len; i++)
                put_byte(8'($urandom), ($urandom_range(9) == 0));
        end
    endtask

    initial
    begin : stimulus
        int phase_start;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_WIDE_MODE;
        cfg_data     = 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_go      = 1'b0;
        items_sent   = 0;
        cur_wide     = 1'b0;
        rst_n        = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // narrow unsigned extremes
        put_byte(8'h00, 1'b0);
        // cap reached with the continuation bit still set
        repeat (5) put_byte(8'hff, 1'b0);
        // end of data with nothing gathered
        put_byte(8'($urandom), 1'b1);
        // end of data mid-value
        put_byte(8'h81, 1'b0);
        put_byte(8'($urandom), 1'b1);

        // wide signed: all ones gives the most negative odd pattern
        write_reg(CFG_WIDE_MODE, 1'b1);
        write_reg(CFG_SIGNED_MODE, 1'b1);
        repeat (9) put_byte(8'hff, 1'b0);
        put_byte(8'h7f, 1'b0);

        // mode change mid-value: seven wide groups, then the narrow cap applies
        repeat (7) put_byte(8'h80, 1'b0);
        write_reg(CFG_WIDE_MODE, 1'b0);
        put_byte(8'h80, 1'b0);

        // write to an unused index, ignored
        write_reg(CFG_UNUSED, 1'b1);

        // random phases over every mode and idling pattern
        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(CFG_WIDE_MODE, phase[0]);
            write_reg(CFG_SIGNED_MODE, phase[1] ^ phase[2]);
            case (phase >> 1)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 82; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 82; end
                default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                // long receiver hold-off while bytes keep coming
                if (phase == 0 && items_sent - phase_start >= 30)
                    hold_go = 1'b1;
                send_random_run();
            end
        end

        // drain
        s_tvalid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
